>>> sv/ipf_pkg.sv
// ipf_pkg: shared types, constants and codes of the IPv4 packet filter.
// No dependencies; imported by every ipf module and the top level.
package ipf_pkg;

  localparam int MAX_PACKET = 2048;
  localparam int WORD_BYTES = 8;
  localparam int WORD_LIMIT = (WORD_BYTES < 8) ? WORD_BYTES : 8;
  localparam int BC_W       = $clog2(MAX_PACKET + 1);

  localparam logic [7:0] PROTO_ICMP        = 8'd1;
  localparam logic [7:0] PROTO_TCP         = 8'd6;
  localparam logic [7:0] PROTO_UDP         = 8'd17;
  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

  localparam logic [31:0] BLOCKED_ADDR_RST = 32'h0A00_0032;  // 10.0.0.50
  localparam logic [63:0] WORD_A_RST       = 64'h006F_6C75_636C_6143;  // "Calculo"
  localparam logic [3:0]  WORD_A_LEN_RST   = 4'd7;
  localparam logic [63:0] WORD_B_RST       = 64'h0000_0000_0000_4D44;  // "DM"
  localparam logic [3:0]  WORD_B_LEN_RST   = 4'd2;

  typedef enum logic [2:0] {
    CFG_BLOCKED_ADDR = 3'd0,
    CFG_WORD_A       = 3'd1,
    CFG_WORD_A_LEN   = 3'd2,
    CFG_WORD_B       = 3'd3,
    CFG_WORD_B_LEN   = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    VERDICT_PASS       = 3'd0,
    VERDICT_BLOCK_ADDR = 3'd1,
    VERDICT_BLOCK_WORD = 3'd2,
    VERDICT_TOO_SHORT  = 3'd3,
    VERDICT_ECHO_REQ   = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [31:0] blocked_addr;
    logic [63:0] word_a;
    logic [3:0]  word_a_len;
    logic [63:0] word_b;
    logic [3:0]  word_b_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    verdict_t        verdict;
    logic [7:0]      protocol_number;
    logic [31:0]     source_addr;
    logic [31:0]     dest_addr;
    logic [BC_W-1:0] packet_bytes;
    logic [15:0]     echo_ident;
    logic [15:0]     echo_sequence;
  } result_t;

endpackage

>>> sv/ipv4_packet_filter_unit.sv
// ipv4_packet_filter_unit: top level of the IPv4 packet filter.
// Depends on ipf_pkg, ipf_cfg_regs, ipf_in_reg, ipf_core, ipf_out_reg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_ready  | data_byte, end_of_packet
//   out      | out_valid/ out_ready | verdict, protocol_number, source_addr,
//            |                      | dest_addr, packet_bytes, echo_ident/sequence
//   cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// One byte per cycle unless a final byte waits on a full result register; the
// verdict is loaded into the result register as the final byte leaves the input
// register. The parser between them is combinational and updates all packet
// state. Reset is synchronous and clears all packet state. Only a final byte
// waits on a full result register; others flow on. cfg_ready is always high.
module ipv4_packet_filter_unit
  import ipf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  verdict,
  output logic [7:0]  protocol_number,
  output logic [31:0] source_addr,
  output logic [31:0] dest_addr,
  output logic [11:0] packet_bytes,
  output logic [15:0] echo_ident,
  output logic [15:0] echo_sequence,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    slot_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_item   = '{data_byte: data_byte, last: end_of_packet};

  ipf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ipf_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ipf_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held_item  (held_item),
    .slot_free  (slot_free),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  ipf_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_res  (res),
    .out_ready (out_ready),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign verdict         = out_res.verdict;
  assign protocol_number = out_res.protocol_number;
  assign source_addr     = out_res.source_addr;
  assign dest_addr       = out_res.dest_addr;
  assign packet_bytes    = 12'(out_res.packet_bytes);
  assign echo_ident      = out_res.echo_ident;
  assign echo_sequence   = out_res.echo_sequence;

  a_echo_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_ECHO_REQ |-> echo_ident == 16'd0 && echo_sequence == 16'd0)
    else $error("echo fields set without echo verdict");

  a_echo_is_icmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_ECHO_REQ |-> protocol_number == PROTO_ICMP)
    else $error("echo verdict on non-ICMP packet");

  a_short_proto: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_TOO_SHORT |->
      protocol_number == PROTO_ICMP || protocol_number == PROTO_TCP ||
      protocol_number == PROTO_UDP)
    else $error("too-short verdict on unchecked protocol");

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packet_bytes != 12'd0)
    else $error("verdict for empty packet");

endmodule

>>> sv/ipf_cfg_regs.sv
// ipf_cfg_regs: configuration register file of the packet filter.
// Depends on ipf_pkg.
module ipf_cfg_regs
  import ipf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blocked_addr <= BLOCKED_ADDR_RST;
      cfg.word_a       <= WORD_A_RST;
      cfg.word_a_len   <= WORD_A_LEN_RST;
      cfg.word_b       <= WORD_B_RST;
      cfg.word_b_len   <= WORD_B_LEN_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_BLOCKED_ADDR: cfg.blocked_addr <= wr_data[31:0];
        CFG_WORD_A:       cfg.word_a       <= wr_data;
        CFG_WORD_A_LEN:   cfg.word_a_len   <= wr_data[3:0];
        CFG_WORD_B:       cfg.word_b       <= wr_data;
        CFG_WORD_B_LEN:   cfg.word_b_len   <= wr_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/ipf_in_reg.sv
// ipf_in_reg: input register holding one packet byte for the parser.
// Depends on ipf_pkg.
module ipf_in_reg
  import ipf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

>>> sv/ipf_core.sv
// ipf_core: per-packet header capture, payload word search and verdict.
// Depends on ipf_pkg.
module ipf_core
  import ipf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    held_valid,
  input  item_t   held_item,
  input  logic    slot_free,
  output logic    advance,
  output logic    res_valid,
  output result_t res
);

  logic [BC_W-1:0] byte_count;
  logic [5:0]      hdr_len;
  logic [7:0]      proto_seen;
  logic [31:0]     src_seen;
  logic [31:0]     dst_seen;
  logic [6:0]      payload_offset;
  logic            payload_known;
  logic [7:0]      icmp_kind;
  logic [15:0]     ident_seen;
  logic [15:0]     seq_seen;
  logic [63:0]     window_bytes;
  logic            word_hit;

  logic [BC_W-1:0] byte_count_next;
  logic [5:0]      hdr_len_next;
  logic [7:0]      proto_next;
  logic [31:0]     src_next;
  logic [31:0]     dst_next;
  logic [6:0]      offset_next;
  logic            known_next;
  logic [7:0]      icmp_next;
  logic [15:0]     ident_next;
  logic [15:0]     seq_next;
  logic [63:0]     window_next;
  logic            hit_next;

  logic [BC_W-1:0] p;
  logic [BC_W-1:0] hdr_w;
  logic [7:0]      b;
  logic            capture;
  logic            is_echo;

  function automatic logic word_match(
    input logic [63:0]     window,
    input logic [63:0]     word,
    input logic [3:0]      len,
    input logic            known,
    input logic [6:0]      offset,
    input logic [BC_W-1:0] pos
  );
    logic [3:0]  lenc;
    logic [6:0]  sh;
    logic [63:0] mask;
    logic        reach;
    lenc  = (len > 4'(WORD_LIMIT)) ? 4'(WORD_LIMIT) : len;
    sh    = 7'd64 - {lenc, 3'b000};
    mask  = {64{1'b1}} >> sh;
    reach = ((BC_W+1)'(pos) + (BC_W+1)'(1)) >=
            ((BC_W+1)'(offset) + (BC_W+1)'(lenc));
    return (lenc != 4'd0) && known && reach &&
           (((window >> sh) & mask) == (word & mask));
  endfunction

  assign b       = held_item.data_byte;
  assign p       = byte_count;
  assign capture = p < BC_W'(MAX_PACKET);
  assign advance = held_valid && (!held_item.last || slot_free);

  always_comb begin
    hdr_len_next = hdr_len;
    proto_next   = proto_seen;
    src_next     = src_seen;
    dst_next     = dst_seen;
    icmp_next    = icmp_kind;
    ident_next   = ident_seen;
    seq_next     = seq_seen;
    offset_next  = payload_offset;
    known_next   = payload_known;
    byte_count_next = byte_count;
    if (capture && p == '0) begin
      hdr_len_next = {b[3:0], 2'b00};
    end
    hdr_w = BC_W'(hdr_len_next);
    if (capture) begin
      if (p == BC_W'(9)) begin
        proto_next = b;
        if (b == PROTO_UDP) begin
          offset_next = 7'(hdr_len_next) + 7'd8;
          known_next  = 1'b1;
        end
      end
      if (p >= BC_W'(12) && p <= BC_W'(15)) src_next = {src_seen[23:0], b};
      if (p >= BC_W'(16) && p <= BC_W'(19)) dst_next = {dst_seen[23:0], b};
      if (p == hdr_w) icmp_next = b;
      if (p == hdr_w + BC_W'(4) || p == hdr_w + BC_W'(5)) ident_next = {ident_seen[7:0], b};
      if (p == hdr_w + BC_W'(6) || p == hdr_w + BC_W'(7)) seq_next = {seq_seen[7:0], b};
      if (p == hdr_w + BC_W'(12) && proto_next == PROTO_TCP) begin
        offset_next = 7'(hdr_len_next) + 7'({b[7:4], 2'b00});
        known_next  = 1'b1;
      end
      byte_count_next = p + BC_W'(1);
    end
    window_next = {b, window_bytes[63:8]};
    hit_next = word_hit ||
               word_match(window_next, cfg.word_a, cfg.word_a_len, known_next, offset_next, p) ||
               word_match(window_next, cfg.word_b, cfg.word_b_len, known_next, offset_next, p);
  end

  always_comb begin
    is_echo     = 1'b0;
    res.verdict = VERDICT_PASS;
    if (dst_next == cfg.blocked_addr) begin
      res.verdict = VERDICT_BLOCK_ADDR;
    end else if (proto_next == PROTO_ICMP) begin
      if (byte_count_next < hdr_w + BC_W'(8)) begin
        res.verdict = VERDICT_TOO_SHORT;
      end else if (icmp_next == ICMP_ECHO_REQUEST) begin
        res.verdict = VERDICT_ECHO_REQ;
        is_echo     = 1'b1;
      end
    end else if (proto_next == PROTO_TCP) begin
      if (byte_count_next < hdr_w + BC_W'(20)) res.verdict = VERDICT_TOO_SHORT;
      else if (hit_next) res.verdict = VERDICT_BLOCK_WORD;
    end else if (proto_next == PROTO_UDP) begin
      if (byte_count_next < hdr_w + BC_W'(8)) res.verdict = VERDICT_TOO_SHORT;
      else if (hit_next) res.verdict = VERDICT_BLOCK_WORD;
    end
    res.protocol_number = proto_next;
    res.source_addr     = src_next;
    res.dest_addr       = dst_next;
    res.packet_bytes    = byte_count_next;
    res.echo_ident      = is_echo ? ident_next : 16'd0;
    res.echo_sequence   = is_echo ? seq_next : 16'd0;
  end

  assign res_valid = advance && held_item.last;

  always_ff @(posedge clk) begin
    if (rst || (advance && held_item.last)) begin
      byte_count     <= '0;
      hdr_len        <= '0;
      proto_seen     <= '0;
      src_seen       <= '0;
      dst_seen       <= '0;
      payload_offset <= '0;
      payload_known  <= 1'b0;
      icmp_kind      <= '0;
      ident_seen     <= '0;
      seq_seen       <= '0;
      window_bytes   <= '0;
      word_hit       <= 1'b0;
    end else if (advance) begin
      byte_count     <= byte_count_next;
      hdr_len        <= hdr_len_next;
      proto_seen     <= proto_next;
      src_seen       <= src_next;
      dst_seen       <= dst_next;
      payload_offset <= offset_next;
      payload_known  <= known_next;
      icmp_kind      <= icmp_next;
      ident_seen     <= ident_next;
      seq_seen       <= seq_next;
      window_bytes   <= window_next;
      word_hit       <= hit_next;
    end
  end

endmodule

>>> sv/ipf_out_reg.sv
// ipf_out_reg: result register holding one verdict until it is taken.
// Depends on ipf_pkg.
module ipf_out_reg
  import ipf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  input  logic    out_ready,
  output logic    slot_free,
  output logic    out_valid,
  output result_t out_res
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_free) begin
      out_res <= load_res;
    end
  end

endmodule

>>> tb/ipf_verdict_checker.sv
// ipf_verdict_checker: watches the byte, verdict and register channels of the
// IPv4 packet filter, predicts each verdict and compares it field by field.
// Depends on ipf_pkg; instantiated beside the block by ipv4_packet_filter_unit_tb.
module ipf_verdict_checker
  import ipf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_packet,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  verdict,
  input  logic [7:0]  protocol_number,
  input  logic [31:0] source_addr,
  input  logic [31:0] dest_addr,
  input  logic [11:0] packet_bytes,
  input  logic [15:0] echo_ident,
  input  logic [15:0] echo_sequence,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatch_count,
  output int          verdicts_pending
);

  cfg_t        regs;
  result_t     expected_verdicts[$];
  result_t     want;

  int unsigned seen_bytes;
  int unsigned ihl_bytes;
  int unsigned payload_start;
  bit          payload_ready;
  logic [7:0]  proto_field;
  logic [31:0] src_field;
  logic [31:0] dst_field;
  logic [7:0]  icmp_type;
  logic [15:0] echo_id;
  logic [15:0] echo_seq;
  logic [63:0] last8;
  bit          word_flag;

  function automatic void clear_packet();
    seen_bytes    = 0;
    ihl_bytes     = 0;
    payload_start = 0;
    payload_ready = 1'b0;
    proto_field   = '0;
    src_field     = '0;
    dst_field     = '0;
    icmp_type     = '0;
    echo_id       = '0;
    echo_seq      = '0;
    last8         = '0;
    word_flag     = 1'b0;
  endfunction

  // p is the position of the newest byte; last8 holds it in the top byte.
  function automatic bit word_in_window(input logic [63:0] w, input logic [3:0] len_field,
                                        input int unsigned p);
    int unsigned n;
    logic [63:0] mask;
    n = (len_field > WORD_LIMIT) ? WORD_LIMIT : len_field;
    if (n == 0 || !payload_ready || p + 1 < payload_start + n) return 1'b0;
    mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    return ((last8 >> (64 - 8 * n)) & mask) == (w & mask);
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned p;
    result_t r;
    p = seen_bytes;
    if (p < MAX_PACKET) begin
      if (p == 0) ihl_bytes = b[3:0] * 4;
      if (p == 9) begin
        proto_field = b;
        if (b == PROTO_UDP) begin
          payload_start = ihl_bytes + 8;
          payload_ready = 1'b1;
        end
      end
      if (p >= 12 && p <= 15) src_field = {src_field[23:0], b};
      if (p >= 16 && p <= 19) dst_field = {dst_field[23:0], b};
      if (p == ihl_bytes) icmp_type = b;
      if (p == ihl_bytes + 4 || p == ihl_bytes + 5) echo_id = {echo_id[7:0], b};
      if (p == ihl_bytes + 6 || p == ihl_bytes + 7) echo_seq = {echo_seq[7:0], b};
      if (p == ihl_bytes + 12 && proto_field == PROTO_TCP) begin
        payload_start = ihl_bytes + b[7:4] * 4;
        payload_ready = 1'b1;
      end
      seen_bytes = p + 1;
    end
    last8 = {b, last8[63:8]};
    if (word_in_window(regs.word_a, regs.word_a_len, p) ||
        word_in_window(regs.word_b, regs.word_b_len, p)) word_flag = 1'b1;
    if (last) begin
      r = '0;
      r.verdict = VERDICT_PASS;
      if (dst_field == regs.blocked_addr) begin
        r.verdict = VERDICT_BLOCK_ADDR;
      end else if (proto_field == PROTO_ICMP) begin
        if (seen_bytes < ihl_bytes + 8) r.verdict = VERDICT_TOO_SHORT;
        else if (icmp_type == ICMP_ECHO_REQUEST) begin
          r.verdict       = VERDICT_ECHO_REQ;
          r.echo_ident    = echo_id;
          r.echo_sequence = echo_seq;
        end
      end else if (proto_field == PROTO_TCP) begin
        if (seen_bytes < ihl_bytes + 20) r.verdict = VERDICT_TOO_SHORT;
        else if (word_flag) r.verdict = VERDICT_BLOCK_WORD;
      end else if (proto_field == PROTO_UDP) begin
        if (seen_bytes < ihl_bytes + 8) r.verdict = VERDICT_TOO_SHORT;
        else if (word_flag) r.verdict = VERDICT_BLOCK_WORD;
      end
      r.protocol_number = proto_field;
      r.source_addr     = src_field;
      r.dest_addr       = dst_field;
      r.packet_bytes    = BC_W'(seen_bytes);
      expected_verdicts.push_back(r);
      clear_packet();
    end
  endtask

  task automatic compare_field(input string field, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.blocked_addr = BLOCKED_ADDR_RST;
      regs.word_a       = WORD_A_RST;
      regs.word_a_len   = WORD_A_LEN_RST;
      regs.word_b       = WORD_B_RST;
      regs.word_b_len   = WORD_B_LEN_RST;
      clear_packet();
      expected_verdicts.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatch_count++;
          $display("%0t: verdict expected none actual %0d", $time, verdict);
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("verdict", 64'(want.verdict), 64'(verdict));
          compare_field("protocol_number", 64'(want.protocol_number),
                        64'(protocol_number));
          compare_field("source_addr", 64'(want.source_addr), 64'(source_addr));
          compare_field("dest_addr", 64'(want.dest_addr), 64'(dest_addr));
          compare_field("packet_bytes", 64'(want.packet_bytes), 64'(packet_bytes));
          compare_field("echo_ident", 64'(want.echo_ident), 64'(echo_ident));
          compare_field("echo_sequence", 64'(want.echo_sequence), 64'(echo_sequence));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCKED_ADDR: regs.blocked_addr = cfg_data[31:0];
          CFG_WORD_A:       regs.word_a       = cfg_data;
          CFG_WORD_A_LEN:   regs.word_a_len   = cfg_data[3:0];
          CFG_WORD_B:       regs.word_b       = cfg_data;
          CFG_WORD_B_LEN:   regs.word_b_len   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) parse_byte(data_byte, end_of_packet);
    end
    verdicts_pending = expected_verdicts.size();
  end

endmodule

>>> tb/ipv4_packet_filter_unit_tb.sv
// ipv4_packet_filter_unit_tb: drives IPv4 packets and register writes into the
// packet filter with random idling; verdicts are checked by ipf_verdict_checker.
// Depends on ipf_pkg, ipv4_packet_filter_unit and ipf_verdict_checker.
module ipv4_packet_filter_unit_tb;
  import ipf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES   = 340;
  localparam int unsigned PHASE_PACKETS = 16;
  localparam logic [2:0]  CFG_UNUSED    = 3'd7;
  localparam logic [7:0]  ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0]  TCP_MIN_DOFF  = 8'd5;
  localparam logic [31:0] HOST_ADDR     = 32'hC0A8_0001;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        end_of_packet = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = CFG_BLOCKED_ADDR;
  logic [63:0] cfg_data = '0;

  wire         in_ready;
  wire         out_valid;
  wire  [2:0]  verdict;
  wire  [7:0]  protocol_number;
  wire  [31:0] source_addr;
  wire  [31:0] dest_addr;
  wire  [11:0] packet_bytes;
  wire  [15:0] echo_ident;
  wire  [15:0] echo_sequence;
  wire         cfg_ready;

  int          mismatch_count;
  int          verdicts_pending;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          idle_en = 1'b0;

  cfg_t        cur_cfg;
  logic [7:0]  pkt[$];
  int unsigned pay_at;
  int unsigned phase_bytes;
  int unsigned phase_packets;

  ipv4_packet_filter_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_packet(end_of_packet),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .protocol_number(protocol_number),
    .source_addr(source_addr), .dest_addr(dest_addr),
    .packet_bytes(packet_bytes), .echo_ident(echo_ident), .echo_sequence(echo_sequence),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ipf_verdict_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_packet(end_of_packet),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .protocol_number(protocol_number),
    .source_addr(source_addr), .dest_addr(dest_addr),
    .packet_bytes(packet_bytes), .echo_ident(echo_ident), .echo_sequence(echo_sequence),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .verdicts_pending(verdicts_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // verdict side back-pressure
  always @(negedge clk) begin
    if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 15);
    if (stall_left != 0) begin
      out_ready  = 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid      = 1'b0;
      data_byte     = 8'($urandom);
      end_of_packet = 1'($urandom);
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid      = 1'b1;
    data_byte     = b;
    end_of_packet = last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    phase_bytes += pkt.size();
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      CFG_BLOCKED_ADDR: cur_cfg.blocked_addr = value[31:0];
      CFG_WORD_A:       cur_cfg.word_a       = value;
      CFG_WORD_A_LEN:   cur_cfg.word_a_len   = value[3:0];
      CFG_WORD_B:       cur_cfg.word_b       = value;
      CFG_WORD_B_LEN:   cur_cfg.word_b_len   = value[3:0];
      default: ;
    endcase
  endtask

  // sub is the ICMP type for ICMP and the data offset for TCP
  task automatic build_packet(input logic [3:0] ihl, input logic [7:0] proto,
                              input logic [31:0] dst, input logic [7:0] sub,
                              input int unsigned pay_len);
    logic [3:0] flags_hi;
    flags_hi = 4'($urandom);
    pkt.delete();
    pkt.push_back({4'h4, ihl});
    repeat (8) pkt.push_back(8'($urandom));
    pkt.push_back(proto);
    repeat (6) pkt.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) pkt.push_back(dst[8*i +: 8]);
    while (pkt.size() < ihl * 4) pkt.push_back(8'($urandom));
    pay_at = pkt.size();
    if (proto == PROTO_ICMP) begin
      pkt.push_back(sub);
      repeat (7) pkt.push_back(8'($urandom));
      pay_at = pkt.size();
    end else if (proto == PROTO_TCP) begin
      repeat (12) pkt.push_back(8'($urandom));
      pkt.push_back({sub[3:0], flags_hi});
      repeat (7) pkt.push_back(8'($urandom));
      while (pkt.size() < pay_at + sub[3:0] * 4) pkt.push_back(8'($urandom));
      pay_at = pkt.size();
    end else if (proto == PROTO_UDP) begin
      repeat (8) pkt.push_back(8'($urandom));
      pay_at = pkt.size();
    end
    repeat (pay_len) pkt.push_back(8'($urandom));
  endtask

  // a disabled word is still planted at full width
  task automatic embed_word(input logic [63:0] w, input logic [3:0] len_field,
                            input int unsigned at);
    int unsigned n;
    n = (len_field == 0 || len_field > 8) ? 8 : len_field;
    for (int unsigned i = 0; i < n; i++)
      if (at + i < pkt.size()) pkt[at + i] = w[8*i +: 8];
  endtask

  task automatic random_packet();
    int unsigned kind;
    int unsigned at;
    int unsigned cut;
    logic [3:0]  ihl;
    logic [7:0]  sub;
    logic [7:0]  proto;
    logic [31:0] dst;
    kind = $urandom_range(0, 19);
    ihl  = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'd5;
    dst  = ($urandom_range(0, 7) == 0) ? cur_cfg.blocked_addr : $urandom;
    if (kind < 5) begin
      sub = ($urandom_range(0, 2) != 0) ? ICMP_ECHO_REQUEST : 8'($urandom);
      build_packet(ihl, PROTO_ICMP, dst, sub, $urandom_range(0, 8));
    end else if (kind < 15) begin
      proto = (kind < 10) ? PROTO_TCP : PROTO_UDP;
      case ($urandom_range(0, 5))
        0:       sub = 8'($urandom_range(0, 4));
        1:       sub = 8'($urandom_range(6, 15));
        default: sub = TCP_MIN_DOFF;
      endcase
      build_packet(ihl, proto, dst, sub, $urandom_range(0, 16));
      if ($urandom_range(0, 2) != 0) begin
        at = $urandom_range((pay_at >= 2) ? pay_at - 2 : 0, pkt.size() - 1);
        if ($urandom_range(0, 1) == 0) embed_word(cur_cfg.word_a, cur_cfg.word_a_len, at);
        else embed_word(cur_cfg.word_b, cur_cfg.word_b_len, at);
      end
    end else if (kind == 15) begin
      build_packet(ihl, 8'($urandom), dst, 8'($urandom), $urandom_range(0, 12));
    end else if (kind < 18) begin
      case ($urandom_range(0, 2))
        0:       proto = PROTO_ICMP;
        1:       proto = PROTO_TCP;
        default: proto = PROTO_UDP;
      endcase
      sub = (proto == PROTO_ICMP) ? ICMP_ECHO_REQUEST : TCP_MIN_DOFF;
      build_packet(ihl, proto, dst, sub, $urandom_range(0, 8));
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end else begin
      pkt.delete();
      repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
    end
    send_packet();
  endtask

  initial begin
    cur_cfg.blocked_addr = BLOCKED_ADDR_RST;
    cur_cfg.word_a       = WORD_A_RST;
    cur_cfg.word_a_len   = WORD_A_LEN_RST;
    cur_cfg.word_b       = WORD_B_RST;
    cur_cfg.word_b_len   = WORD_B_LEN_RST;
    repeat (8) @(negedge clk);
    rst     = 1'b0;
    idle_en = 1'b1;

    // runts
    pkt.delete();
    pkt.push_back(8'hFF);
    send_packet();
    pkt.delete();
    pkt.push_back(8'h00);
    send_packet();

    // echo requests with extreme identifier and sequence, an echo reply, a truncated request
    build_packet(4'd5, PROTO_ICMP, HOST_ADDR, ICMP_ECHO_REQUEST, 4);
    pkt[24] = 8'hFF; pkt[25] = 8'hFF; pkt[26] = 8'h00; pkt[27] = 8'h00;
    send_packet();
    build_packet(4'd5, PROTO_ICMP, HOST_ADDR, ICMP_ECHO_REQUEST, 0);
    pkt[24] = 8'h00; pkt[25] = 8'h00; pkt[26] = 8'hFF; pkt[27] = 8'hFF;
    send_packet();
    build_packet(4'd5, PROTO_ICMP, HOST_ADDR, ICMP_ECHO_REPLY, 2);
    send_packet();
    build_packet(4'd5, PROTO_ICMP, HOST_ADDR, ICMP_ECHO_REQUEST, 0);
    void'(pkt.pop_back());
    send_packet();

    build_packet(4'd5, PROTO_UDP, BLOCKED_ADDR_RST, 8'h00, 4);
    send_packet();

    build_packet(4'd5, PROTO_TCP, HOST_ADDR, TCP_MIN_DOFF, 10);
    embed_word(cur_cfg.word_a, cur_cfg.word_a_len, pay_at);
    send_packet();
    build_packet(4'd5, PROTO_TCP, HOST_ADDR, TCP_MIN_DOFF, 0);
    void'(pkt.pop_back());
    send_packet();

    build_packet(4'd5, PROTO_UDP, HOST_ADDR, 8'h00, 6);
    embed_word(cur_cfg.word_b, cur_cfg.word_b_len, pay_at + 3);
    send_packet();
    build_packet(4'd5, PROTO_UDP, HOST_ADDR, 8'h00, 0);
    void'(pkt.pop_back());
    send_packet();

    // zero IHL UDP: word ends before the payload start is known
    build_packet(4'd0, PROTO_UDP, HOST_ADDR, 8'h00, 0);
    embed_word(cur_cfg.word_b, cur_cfg.word_b_len, 7);
    send_packet();

    // zero data offset TCP: word ending before and after the offset byte
    build_packet(4'd5, PROTO_TCP, HOST_ADDR, 8'h00, 4);
    embed_word(cur_cfg.word_b, cur_cfg.word_b_len, 30);
    send_packet();
    build_packet(4'd5, PROTO_TCP, HOST_ADDR, 8'h00, 4);
    embed_word(cur_cfg.word_b, cur_cfg.word_b_len, 33);
    send_packet();

    build_packet(4'd15, PROTO_TCP, HOST_ADDR, 8'h0F, 8);
    embed_word(cur_cfg.word_a, cur_cfg.word_a_len, pay_at);
    send_packet();
    build_packet(4'd2, PROTO_UDP, HOST_ADDR, 8'h00, 4);
    send_packet();
    build_packet(4'd5, 8'hFF, HOST_ADDR, 8'h00, 6);
    send_packet();

    // overlong packet with the word past the size limit
    build_packet(4'd5, PROTO_UDP, HOST_ADDR, 8'h00, 2040);
    embed_word(cur_cfg.word_a, cur_cfg.word_a_len, pkt.size() - 7);
    send_packet();
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_BLOCKED_ADDR, 64'd0);
          write_reg(CFG_WORD_A, 64'd0);
          write_reg(CFG_WORD_A_LEN, 64'd0);
          write_reg(CFG_WORD_B, '1);
          write_reg(CFG_WORD_B_LEN, 64'd8);
          write_reg(CFG_UNUSED, {$urandom, $urandom});
        end
        1: begin
          write_reg(CFG_BLOCKED_ADDR, 64'hFFFF_FFFF);
          write_reg(CFG_WORD_A, {$urandom, $urandom});
          write_reg(CFG_WORD_A_LEN, 64'd15);
          write_reg(CFG_WORD_B, {$urandom, $urandom});
          write_reg(CFG_WORD_B_LEN, 64'd1);
        end
        2: begin
          write_reg(CFG_BLOCKED_ADDR, 64'($urandom));
          write_reg(CFG_WORD_A, {$urandom, $urandom});
          write_reg(CFG_WORD_A_LEN, 64'($urandom_range(1, 8)));
          write_reg(CFG_WORD_B, {$urandom, $urandom});
          write_reg(CFG_WORD_B_LEN, 64'd0);
        end
        default: begin
          write_reg(CFG_BLOCKED_ADDR, 64'($urandom));
          write_reg(CFG_WORD_A, {$urandom, $urandom});
          write_reg(CFG_WORD_A_LEN, 64'($urandom_range(0, 15)));
          write_reg(CFG_WORD_B, {$urandom, $urandom});
          write_reg(CFG_WORD_B_LEN, 64'($urandom_range(0, 15)));
        end
      endcase
      phase_bytes   = 0;
      phase_packets = 0;
      while (phase_bytes < PHASE_BYTES || phase_packets < PHASE_PACKETS) begin
        idle_en = (phase < 3) && ($urandom_range(0, 3) != 0);
        random_packet();
        phase_packets++;
        if (phase == 1 && phase_packets == 8) wait_idle();
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
